[rtl/core/lcp_pkg.sv]
package lcp_pkg;

	localparam int CHANNELS    = 4;
	localparam int COUNT_WIDTH = 32;

	localparam int OP_WIDTH    = 3;
	localparam int CH_WIDTH    = 2;
	localparam int TIME_WIDTH  = 32;
	localparam int REG_WIDTH   = 16;
	localparam int IDX_WIDTH   = 2;
	localparam int OUT_WIDTH   = 32;
	localparam int SEC_WIDTH   = 6;

	localparam logic [SEC_WIDTH-1:0] SEC_PER_MIN = SEC_WIDTH'(60);
	localparam logic [SEC_WIDTH-1:0] MIN_PER_HR  = SEC_WIDTH'(60);

	localparam logic [REG_WIDTH-1:0] LED_PERIOD_RST   = REG_WIDTH'(12);
	localparam logic [REG_WIDTH-1:0] COUNT_PERIOD_RST = REG_WIDTH'(1);
	localparam logic [REG_WIDTH-1:0] DEBOUNCE_RST     = REG_WIDTH'(600);

	typedef enum logic [OP_WIDTH-1:0] {
		OP_TICK      = 3'd0,
		OP_PULSE     = 3'd1,
		OP_START     = 3'd2,
		OP_INJ_BEGIN = 3'd3,
		OP_INJ_END   = 3'd4,
		OP_LED       = 3'd5
	} op_t;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_LED_PERIOD   = 2'd0,
		REG_COUNT_PERIOD = 2'd1,
		REG_DEBOUNCE     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [OP_WIDTH-1:0]   op;
		logic [CH_WIDTH-1:0]   channel;
		logic                  level;
		logic [TIME_WIDTH-1:0] time_ms;
		logic                  keep_on;
		logic                  led_value;
	} item_t;

	typedef struct packed {
		logic led;
		logic fast;
		logic snap;
	} sched_res_t;

endpackage

[rtl/core/lcp_pulse.sv]
module lcp_pulse (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  lcp_pkg::item_t                       item,
	input  logic [lcp_pkg::REG_WIDTH-1:0]        debounce,
	output logic [lcp_pkg::COUNT_WIDTH-1:0]      counts [lcp_pkg::CHANNELS]
);

	logic [lcp_pkg::COUNT_WIDTH-1:0] counts_q [lcp_pkg::CHANNELS];
	logic [lcp_pkg::TIME_WIDTH-1:0]  last_q   [lcp_pkg::CHANNELS];
	logic [lcp_pkg::CHANNELS-1:0]    hit;

	// wrap-safe gap since the last accepted edge on each channel
	always_comb begin
		for (int i = 0; i < lcp_pkg::CHANNELS; i++) begin
			hit[i] = item.level
				&& (32'(item.channel) == 32'(i))
				&& ((item.time_ms - last_q[i]) >= lcp_pkg::TIME_WIDTH'(debounce));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lcp_pkg::CHANNELS; i++) begin
				counts_q[i] <= '0;
				last_q[i]   <= '0;
			end
		end else if (fire) begin
			for (int i = 0; i < lcp_pkg::CHANNELS; i++) begin
				if (item.op == lcp_pkg::OP_START) begin
					counts_q[i] <= '0;
				end else if (item.op == lcp_pkg::OP_PULSE && hit[i]) begin
					counts_q[i] <= counts_q[i] + 1'b1;
					last_q[i]   <= item.time_ms;
				end
			end
		end
	end

	assign counts = counts_q;

	property p_start_clears;
		@(posedge clk) disable iff (!arst_n)
		(fire && item.op == lcp_pkg::OP_START) |=> (counts_q[0] == '0);
	endproperty
	a_start_clears: assert property (p_start_clears)
		else $error("start did not clear channel 0 count");

	property p_low_level_ignored;
		@(posedge clk) disable iff (!arst_n)
		(fire && item.op == lcp_pkg::OP_PULSE && !item.level) |=> $stable(counts_q[0]);
	endproperty
	a_low_level_ignored: assert property (p_low_level_ignored)
		else $error("low-level edge changed a count");

	property p_one_hit;
		@(posedge clk) disable iff (!arst_n)
		fire |-> $onehot0(hit);
	endproperty
	a_one_hit: assert property (p_one_hit)
		else $error("edge matched more than one channel");

endmodule

[rtl/core/lcp_sched.sv]
module lcp_sched (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  lcp_pkg::item_t                item,
	input  logic [lcp_pkg::REG_WIDTH-1:0] led_period,
	input  logic [lcp_pkg::REG_WIDTH-1:0] count_period,
	output lcp_pkg::sched_res_t           res
);

	logic                          running_q;
	logic [lcp_pkg::SEC_WIDTH-1:0] sec_q, min_q;
	logic [lcp_pkg::REG_WIDTH-1:0] mss_q, hst_q;
	logic                          phase_q, led_q, hold_q, fast_q, keep_q;

	logic                          running_d;
	logic [lcp_pkg::SEC_WIDTH-1:0] sec_d, min_d, sec_inc, min_inc;
	logic [lcp_pkg::REG_WIDTH-1:0] mss_d, hst_d;
	logic                          phase_d, led_d, hold_d, fast_d, keep_d, snap_d;

	always_comb begin
		running_d = running_q;
		sec_d     = sec_q;
		min_d     = min_q;
		mss_d     = mss_q;
		hst_d     = hst_q;
		phase_d   = phase_q;
		led_d     = led_q;
		hold_d    = hold_q;
		fast_d    = fast_q;
		keep_d    = keep_q;
		snap_d    = 1'b0;
		sec_inc   = sec_q + 1'b1;
		min_inc   = min_q + 1'b1;

		case (item.op)
			lcp_pkg::OP_TICK: begin
				if (running_q) begin
					sec_d = sec_inc;
					if (sec_inc >= lcp_pkg::SEC_PER_MIN) begin
						sec_d = '0;
						mss_d = (&mss_q) ? mss_q : mss_q + 1'b1;
						min_d = min_inc;
						if (min_inc >= lcp_pkg::MIN_PER_HR) begin
							min_d = '0;
							hst_d = (&hst_q) ? hst_q : hst_q + 1'b1;
						end
					end
					// a due snapshot takes priority over the LED toggle
					if (count_period != '0 && mss_d >= count_period) begin
						mss_d  = '0;
						snap_d = 1'b1;
					end else if (led_period != '0 && hst_d >= led_period) begin
						hst_d = '0;
						if (!hold_q) begin
							phase_d = !phase_q;
							led_d   = !phase_q;
						end
					end
				end
			end
			lcp_pkg::OP_START: begin
				running_d = 1'b1;
				led_d     = 1'b1;
			end
			lcp_pkg::OP_INJ_BEGIN: begin
				keep_d = running_q & item.keep_on;
				hold_d = 1'b1;
				fast_d = 1'b1;
				led_d  = 1'b1;
			end
			lcp_pkg::OP_INJ_END: begin
				if (!keep_q) begin
					led_d = 1'b0;
				end
				hold_d = 1'b0;
				fast_d = 1'b0;
			end
			lcp_pkg::OP_LED: begin
				led_d = item.led_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			sec_q     <= '0;
			min_q     <= '0;
			mss_q     <= '0;
			hst_q     <= '0;
			phase_q   <= 1'b1;
			led_q     <= 1'b0;
			hold_q    <= 1'b0;
			fast_q    <= 1'b0;
			keep_q    <= 1'b0;
		end else if (fire) begin
			running_q <= running_d;
			sec_q     <= sec_d;
			min_q     <= min_d;
			mss_q     <= mss_d;
			hst_q     <= hst_d;
			phase_q   <= phase_d;
			led_q     <= led_d;
			hold_q    <= hold_d;
			fast_q    <= fast_d;
			keep_q    <= keep_d;
		end
	end

	assign res.led  = led_d;
	assign res.fast = fast_d;
	assign res.snap = snap_d;

	property p_snap_needs_run;
		@(posedge clk) disable iff (!arst_n)
		snap_d |-> running_q;
	endproperty
	a_snap_needs_run: assert property (p_snap_needs_run)
		else $error("snapshot before start");

	property p_inject_forces_led;
		@(posedge clk) disable iff (!arst_n)
		(fire && item.op == lcp_pkg::OP_INJ_BEGIN) |=> (led_q && fast_q && hold_q);
	endproperty
	a_inject_forces_led: assert property (p_inject_forces_led)
		else $error("inject begin did not force LED on in fast mode");

	property p_fast_tracks_hold;
		@(posedge clk) disable iff (!arst_n)
		fast_q == hold_q;
	endproperty
	a_fast_tracks_hold: assert property (p_fast_tracks_hold)
		else $error("fast mode and inject hold out of step");

	property p_seconds_wrap;
		@(posedge clk) disable iff (!arst_n)
		(sec_q < lcp_pkg::SEC_PER_MIN) && (min_q < lcp_pkg::MIN_PER_HR);
	endproperty
	a_seconds_wrap: assert property (p_seconds_wrap)
		else $error("second or minute counter out of range");

endmodule

[rtl/core/led_cycle_and_pulse_counter_top.sv]
// Channel  Handshake                Payload
// in       in_valid / in_ready      op, channel, level, time_ms, keep_on, led_value
// out      out_valid / out_ready    led_lit, fast_mode, snapshot_valid, count_zero..three
// config   wr_en (no wait)          wr_index, wr_data
//
// One item per cycle sustained while out_ready is high; an item moves from the input register
// to the output register, and its result transfers out when out_valid and out_ready are both high.
// An item sits in the input register, is evaluated against the live state in one pass,
// and its result lands in the output register in the same edge the state updates.
// The input register accepts a new item whenever its content moves on, so a stalled
// output holds one result and one pending item before in_ready drops.
// Reset (arst_n low) returns state, counts, valid flags and config registers to their defaults.
module led_cycle_and_pulse_counter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lcp_pkg::OP_WIDTH-1:0]    op,
	input  logic [lcp_pkg::CH_WIDTH-1:0]    channel,
	input  logic                            level,
	input  logic [lcp_pkg::TIME_WIDTH-1:0]  time_ms,
	input  logic                            keep_on,
	input  logic                            led_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            led_lit,
	output logic                            fast_mode,
	output logic                            snapshot_valid,
	output logic [lcp_pkg::OUT_WIDTH-1:0]   count_zero,
	output logic [lcp_pkg::OUT_WIDTH-1:0]   count_one,
	output logic [lcp_pkg::OUT_WIDTH-1:0]   count_two,
	output logic [lcp_pkg::OUT_WIDTH-1:0]   count_three,
	input  logic                            wr_en,
	input  logic [lcp_pkg::IDX_WIDTH-1:0]   wr_index,
	input  logic [lcp_pkg::REG_WIDTH-1:0]   wr_data
);

	localparam int OUT_CH = 4;

	logic [lcp_pkg::REG_WIDTH-1:0] led_period_q, count_period_q, debounce_q;

	lcp_pkg::item_t item_s1;
	logic           valid_s1;
	logic           advance;
	logic           in_xfer;

	logic                             out_valid_q;
	logic                             led_q, fast_q, snap_q;
	logic [lcp_pkg::OUT_WIDTH-1:0]    cnt_q [OUT_CH];
	logic [lcp_pkg::OUT_WIDTH-1:0]    cnt_d [OUT_CH];

	logic [lcp_pkg::COUNT_WIDTH-1:0]  counts [lcp_pkg::CHANNELS];
	lcp_pkg::sched_res_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_period_q   <= lcp_pkg::LED_PERIOD_RST;
			count_period_q <= lcp_pkg::COUNT_PERIOD_RST;
			debounce_q     <= lcp_pkg::DEBOUNCE_RST;
		end else if (wr_en) begin
			case (wr_index)
				lcp_pkg::REG_LED_PERIOD:   led_period_q   <= wr_data;
				lcp_pkg::REG_COUNT_PERIOD: count_period_q <= wr_data;
				lcp_pkg::REG_DEBOUNCE:     debounce_q     <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.op        <= op;
			item_s1.channel   <= channel;
			item_s1.level     <= level;
			item_s1.time_ms   <= time_ms;
			item_s1.keep_on   <= keep_on;
			item_s1.led_value <= led_value;
		end
	end

	lcp_pulse u_pulse (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.debounce (debounce_q),
		.counts   (counts)
	);

	lcp_sched u_sched (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.led_period   (led_period_q),
		.count_period (count_period_q),
		.res          (res)
	);

	// channels that do not exist report zero; live channels report zero unless a snapshot is taken
	for (genvar g = 0; g < OUT_CH; g++) begin : g_cnt
		if (g < lcp_pkg::CHANNELS) begin : g_live
			assign cnt_d[g] = res.snap ? lcp_pkg::OUT_WIDTH'(counts[g]) : '0;
		end else begin : g_none
			assign cnt_d[g] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_q  <= res.led;
			fast_q <= res.fast;
			snap_q <= res.snap;
			for (int i = 0; i < OUT_CH; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign led_lit        = led_q;
	assign fast_mode      = fast_q;
	assign snapshot_valid = snap_q;
	assign count_zero     = cnt_q[0];
	assign count_one      = cnt_q[1];
	assign count_two      = cnt_q[2];
	assign count_three    = cnt_q[3];

	property p_hold_pending;
		@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1;
	endproperty
	a_hold_pending: assert property (p_hold_pending)
		else $error("pending item dropped");

	property p_zero_when_no_snap;
		@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !snap_q) |-> (cnt_q[0] == '0 && cnt_q[1] == '0
			&& cnt_q[2] == '0 && cnt_q[3] == '0);
	endproperty
	a_zero_when_no_snap: assert property (p_zero_when_no_snap)
		else $error("counts reported without snapshot");

	property p_advance_fills_out;
		@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q;
	endproperty
	a_advance_fills_out: assert property (p_advance_fills_out)
		else $error("processed item produced no result");

endmodule
